### hw/rtl/lpm_pkg.sv
`timescale 1ns / 1ps

package lpm_pkg;

    // Coordinate format
    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int CRD_W           = COORD_INT_BITS + COORD_FRAC_BITS;

    // Sizes and derived widths
    localparam int SZ_W      = 13;
    localparam int SIZE_MAX  = 4096;
    localparam int OFF_W     = SZ_W - 1;
    localparam int CORNER_W  = 12;
    localparam int HALF_W    = SZ_W + COORD_FRAC_BITS;      // w2, h2, radius
    localparam int RR_W      = 2 * HALF_W;
    localparam int PROD_W    = CRD_W + SZ_W;                // diff * content size

    // Point pipeline
    localparam int NST        = 15;
    localparam int DIV_STEPS  = CRD_W;
    localparam int STEP_PER   = 2;
    localparam int DIV_STG    = DIV_STEPS / STEP_PER;
    localparam int ST_MAPPED  = 3 + DIV_STG + 1;

    // Setup divider
    localparam int VNUM_W = 2 * SZ_W;
    localparam int VDEN_W = SZ_W + 1;
    localparam int VCNT_W = 5;

    // Register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_RENDER_W  = 3'd0;
    localparam logic [2:0] REG_RENDER_H  = 3'd1;
    localparam logic [2:0] REG_CONTENT_W = 3'd2;
    localparam logic [2:0] REG_CONTENT_H = 3'd3;
    localparam logic [2:0] REG_ASPECT    = 3'd4;
    localparam logic [2:0] REG_SHAPE     = 3'd5;
    localparam logic [2:0] REG_CORNER    = 3'd6;

    // Shape codes
    localparam logic [1:0] SHAPE_RECT   = 2'd0;
    localparam logic [1:0] SHAPE_ROUND  = 2'd1;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SEL,
        ST_DIV,
        ST_VIEW,
        ST_SQR
    } setup_state_t;

    // Viewport and shape constants derived from the registers
    typedef struct packed {
        logic [OFF_W-1:0]  vx;
        logic [OFF_W-1:0]  vy;
        logic [SZ_W-1:0]   vw;
        logic [SZ_W-1:0]   vh;
        logic [SZ_W-1:0]   cw;
        logic [SZ_W-1:0]   ch;
        logic [HALF_W-1:0] w2;
        logic [HALF_W-1:0] h2;
        logic [HALF_W-1:0] rad;
        logic [RR_W-1:0]   rr;
        logic [1:0]        kind;
        logic              zero;
    } view_t;

    // Clip a size register: zero acts as one, oversize as the maximum
    function automatic logic [SZ_W-1:0] size_eff(input logic [SZ_W-1:0] v);
        logic [SZ_W-1:0] r;
        begin
            r = v;
            if (v == '0) r = SZ_W'(1);
            else if (v > SZ_W'(SIZE_MAX)) r = SZ_W'(SIZE_MAX);
            return r;
        end
    endfunction

endpackage

### hw/rtl/letterbox_pointer_map_shape_test_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Direction
// s_        s_valid s_ready s_pointer_x s_pointer_y      in  (pointer words)
// m_        m_valid m_ready m_content_x m_content_y      out (mapped words)
//           m_is_inside
// apb       psel penable pwrite paddr pwdata prdata      register access
//           pready
//
// Fifteen register stages: a word accepted on s_ passes through them to m_; one word
// enters per cycle while m_ready holds the pipe moving and the sequencer is idle. The depth
// is set by the 16-bit quotient divider, two bits per stage, in each axis.
// After reset and after the last of any run of register writes the viewport
// sequencer runs its products, a 26-step divide and the view update, with s_ready low.
// Reset is synchronous, active low, and clears the valid bits of all stages.
// Stages hold independently: a bubble is filled while later stages are stalled.

module letterbox_pointer_map_shape_test_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [15:0]                s_pointer_x,
    input  logic [15:0]                s_pointer_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [15:0]                m_content_x,
    output logic [15:0]                m_content_y,
    output logic                       m_is_inside,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int HW = lpm_pkg::HALF_W;
    localparam int NS = lpm_pkg::NST;
    localparam int SM = lpm_pkg::ST_MAPPED;

    lpm_pkg::view_t view;
    logic           busy;

    logic [NS:1]   v_reg;
    logic [NS+1:1] en;

    logic [lpm_pkg::CRD_W-1:0] mx, my;
    logic                      ivx, ivy;

    logic [lpm_pkg::CRD_W-1:0] x13_reg, y13_reg, x14_reg, y14_reg;
    logic [HW-1:0]             ax13_reg, ay13_reg;
    logic                      cor13_reg, cor14_reg, iv13_reg, iv14_reg;
    logic [2*HW-1:0]           sqx_reg, sqy_reg;
    logic [15:0]               cx_reg, cy_reg;
    logic                      in_reg;

    logic signed [HW+1:0]      pxs, pys;
    logic [HW:0]               apx, apy;
    logic signed [HW+2:0]      dxs, dys;
    logic [HW-1:0]             ox, oy;
    logic [2*HW:0]             dsum;
    logic                      in_radius, shape_ok;

    lpm_setup u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .view    (view),
        .busy    (busy)
    );

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        en[NS+1] = m_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[1] && !busy;
    assign m_valid = v_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_valid && s_ready;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    lpm_axis u_axis_x (
        .aclk (aclk),
        .en   (en[NS:1]),
        .p    (s_pointer_x),
        .off  (view.vx),
        .vsz  (view.vw),
        .csz  (view.cw),
        .m    (mx),
        .invp (ivx)
    );

    lpm_axis u_axis_y (
        .aclk (aclk),
        .en   (en[NS:1]),
        .p    (s_pointer_y),
        .off  (view.vy),
        .vsz  (view.vh),
        .csz  (view.ch),
        .m    (my),
        .invp (ivy)
    );

    // Distances from the center and from the corner arcs, doubled fixed point
    always_comb begin
        pxs = $signed({2'b00, mx, 1'b0}) - $signed({2'b00, view.w2});
        pys = $signed({2'b00, my, 1'b0}) - $signed({2'b00, view.h2});
        apx = pxs[HW+1] ? (HW+1)'(-pxs) : (HW+1)'(pxs);
        apy = pys[HW+1] ? (HW+1)'(-pys) : (HW+1)'(pys);
        dxs = $signed({2'b00, apx}) - $signed({3'b000, view.w2})
            + $signed({3'b000, view.rad});
        dys = $signed({2'b00, apy}) - $signed({3'b000, view.h2})
            + $signed({3'b000, view.rad});
        ox  = (dxs > 0) ? HW'(dxs) : '0;
        oy  = (dys > 0) ? HW'(dys) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en[SM+1]) begin
            x13_reg   <= mx;
            y13_reg   <= my;
            iv13_reg  <= ivx && ivy;
            cor13_reg <= (dxs <= 0) && (dys <= 0);
            ax13_reg  <= (view.kind == lpm_pkg::SHAPE_CIRCLE) ? HW'(apx) : ox;
            ay13_reg  <= (view.kind == lpm_pkg::SHAPE_CIRCLE) ? HW'(apy) : oy;
        end
    end

    // Square the distances
    always_ff @(posedge aclk) begin
        if (en[SM+2]) begin
            x14_reg   <= x13_reg;
            y14_reg   <= y13_reg;
            iv14_reg  <= iv13_reg;
            cor14_reg <= cor13_reg;
            sqx_reg   <= ax13_reg * ax13_reg;
            sqy_reg   <= ay13_reg * ay13_reg;
        end
    end

    // Compare against the squared radius and pick by shape
    always_comb begin
        dsum      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        in_radius = (dsum <= (2*HW+1)'(view.rr));
        case (view.kind)
            lpm_pkg::SHAPE_ROUND:  shape_ok = cor14_reg || in_radius;
            lpm_pkg::SHAPE_CIRCLE: shape_ok = in_radius;
            default:               shape_ok = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[NS]) begin
            if (view.zero) begin
                cx_reg <= '0;
                cy_reg <= '0;
                in_reg <= 1'b0;
            end else begin
                cx_reg <= x14_reg;
                cy_reg <= y14_reg;
                in_reg <= iv14_reg && shape_ok;
            end
        end
    end

    assign m_content_x = cx_reg;
    assign m_content_y = cy_reg;
    assign m_is_inside = in_reg;

endmodule

### hw/rtl/lpm_setup.sv
`timescale 1ns / 1ps

module lpm_setup (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lpm_pkg::view_t             view,
    output logic                       busy
);

    logic [lpm_pkg::SZ_W-1:0]     rw_cfg_reg, rh_cfg_reg, cw_cfg_reg, ch_cfg_reg;
    logic                         aspect_reg;
    logic [1:0]                   shape_reg;
    logic [lpm_pkg::CORNER_W-1:0] corner_reg;

    lpm_pkg::setup_state_t state_reg, state_next;

    logic [lpm_pkg::SZ_W-1:0]   rw, rh, cw, ch;
    logic [lpm_pkg::VNUM_W-1:0] pa_reg, pb_reg;
    logic                       wide_reg;
    logic [lpm_pkg::VNUM_W-1:0] nq_reg;
    logic [lpm_pkg::VDEN_W-1:0] rem_reg, den_reg;
    logic [lpm_pkg::VCNT_W-1:0] cnt_reg;
    lpm_pkg::view_t             view_reg;

    logic                       wr;
    logic [2:0]                 idx;
    logic [lpm_pkg::VDEN_W:0]   trial;
    logic [lpm_pkg::SZ_W-1:0]   qc, lim, vw_n, vh_n;
    logic [lpm_pkg::HALF_W-1:0] w2_n, h2_n, side, cr, rad_n;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign busy   = (state_reg != lpm_pkg::ST_IDLE);
    assign view   = view_reg;

    assign rw = lpm_pkg::size_eff(rw_cfg_reg);
    assign rh = lpm_pkg::size_eff(rh_cfg_reg);
    assign cw = lpm_pkg::size_eff(cw_cfg_reg);
    assign ch = lpm_pkg::size_eff(ch_cfg_reg);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rw_cfg_reg <= lpm_pkg::SZ_W'(1);
            rh_cfg_reg <= lpm_pkg::SZ_W'(1);
            cw_cfg_reg <= lpm_pkg::SZ_W'(1);
            ch_cfg_reg <= lpm_pkg::SZ_W'(1);
            aspect_reg <= 1'b0;
            shape_reg  <= lpm_pkg::SHAPE_RECT;
            corner_reg <= '0;
        end else if (wr) begin
            case (idx)
                lpm_pkg::REG_RENDER_W:  rw_cfg_reg <= pwdata[lpm_pkg::SZ_W-1:0];
                lpm_pkg::REG_RENDER_H:  rh_cfg_reg <= pwdata[lpm_pkg::SZ_W-1:0];
                lpm_pkg::REG_CONTENT_W: cw_cfg_reg <= pwdata[lpm_pkg::SZ_W-1:0];
                lpm_pkg::REG_CONTENT_H: ch_cfg_reg <= pwdata[lpm_pkg::SZ_W-1:0];
                lpm_pkg::REG_ASPECT:    aspect_reg <= pwdata[0];
                lpm_pkg::REG_SHAPE:     shape_reg  <= pwdata[1:0];
                lpm_pkg::REG_CORNER:    corner_reg <= pwdata[lpm_pkg::CORNER_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (idx)
            lpm_pkg::REG_RENDER_W:  prdata = 32'(rw_cfg_reg);
            lpm_pkg::REG_RENDER_H:  prdata = 32'(rh_cfg_reg);
            lpm_pkg::REG_CONTENT_W: prdata = 32'(cw_cfg_reg);
            lpm_pkg::REG_CONTENT_H: prdata = 32'(ch_cfg_reg);
            lpm_pkg::REG_ASPECT:    prdata = 32'(aspect_reg);
            lpm_pkg::REG_SHAPE:     prdata = 32'(shape_reg);
            lpm_pkg::REG_CORNER:    prdata = 32'(corner_reg);
            default:                prdata = '0;
        endcase
    end

    // Next state: rerun the viewport calculation after every write
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpm_pkg::ST_IDLE: if (wr) state_next = lpm_pkg::ST_PROD;
            lpm_pkg::ST_PROD: state_next = lpm_pkg::ST_SEL;
            lpm_pkg::ST_SEL:  state_next = lpm_pkg::ST_DIV;
            lpm_pkg::ST_DIV:
                if (cnt_reg == lpm_pkg::VCNT_W'(lpm_pkg::VNUM_W - 1))
                    state_next = lpm_pkg::ST_VIEW;
            lpm_pkg::ST_VIEW: state_next = lpm_pkg::ST_SQR;
            lpm_pkg::ST_SQR:  state_next = lpm_pkg::ST_IDLE;
            default:          state_next = lpm_pkg::ST_IDLE;
        endcase
        // Restart from the products when a write lands mid-run
        if (wr) state_next = lpm_pkg::ST_PROD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpm_pkg::ST_PROD;
        end else begin
            state_reg <= state_next;
        end
    end

    // One restoring divide step
    assign trial = {rem_reg, nq_reg[lpm_pkg::VNUM_W-1]} - {1'b0, den_reg};

    // Rounded quotient clipped to 1..render size
    always_comb begin
        lim  = wide_reg ? rw : rh;
        qc   = lpm_pkg::SZ_W'(nq_reg);
        if (nq_reg == '0) qc = lpm_pkg::SZ_W'(1);
        else if (nq_reg > lpm_pkg::VNUM_W'(lim)) qc = lim;
        vw_n = rw;
        vh_n = rh;
        if (aspect_reg) begin
            if (wide_reg) vw_n = qc;
            else          vh_n = qc;
        end
        w2_n  = {cw, {lpm_pkg::COORD_FRAC_BITS{1'b0}}};
        h2_n  = {ch, {lpm_pkg::COORD_FRAC_BITS{1'b0}}};
        side  = (w2_n < h2_n) ? w2_n : h2_n;
        cr    = {corner_reg, {(lpm_pkg::COORD_FRAC_BITS + 1){1'b0}}};
        rad_n = side;
        if (shape_reg == lpm_pkg::SHAPE_ROUND && cr < side) rad_n = cr;
    end

    // Datapath of the sequencer
    always_ff @(posedge aclk) begin
        case (state_reg)
            lpm_pkg::ST_PROD: begin
                pa_reg <= rw * ch;
                pb_reg <= cw * rh;
            end
            lpm_pkg::ST_SEL: begin
                wide_reg <= (pa_reg > pb_reg);
                rem_reg  <= '0;
                cnt_reg  <= '0;
                if (pa_reg > pb_reg) begin
                    nq_reg  <= {pb_reg[lpm_pkg::VNUM_W-2:0], 1'b0} + lpm_pkg::VNUM_W'(ch);
                    den_reg <= {ch, 1'b0};
                end else begin
                    nq_reg  <= {pa_reg[lpm_pkg::VNUM_W-2:0], 1'b0} + lpm_pkg::VNUM_W'(cw);
                    den_reg <= {cw, 1'b0};
                end
            end
            lpm_pkg::ST_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!trial[lpm_pkg::VDEN_W]) begin
                    rem_reg <= trial[lpm_pkg::VDEN_W-1:0];
                    nq_reg  <= {nq_reg[lpm_pkg::VNUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[lpm_pkg::VDEN_W-2:0], nq_reg[lpm_pkg::VNUM_W-1]};
                    nq_reg  <= {nq_reg[lpm_pkg::VNUM_W-2:0], 1'b0};
                end
            end
            lpm_pkg::ST_VIEW: begin
                view_reg.vw   <= vw_n;
                view_reg.vh   <= vh_n;
                view_reg.vx   <= lpm_pkg::OFF_W'((rw - vw_n) >> 1);
                view_reg.vy   <= lpm_pkg::OFF_W'((rh - vh_n) >> 1);
                view_reg.cw   <= cw;
                view_reg.ch   <= ch;
                view_reg.w2   <= w2_n;
                view_reg.h2   <= h2_n;
                view_reg.rad  <= rad_n;
                view_reg.kind <= shape_reg;
                view_reg.zero <= (cw_cfg_reg == '0) || (ch_cfg_reg == '0);
            end
            lpm_pkg::ST_SQR: begin
                view_reg.rr <= view_reg.rad * view_reg.rad;
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/lpm_axis.sv
`timescale 1ns / 1ps

module lpm_axis (
    input  logic                      aclk,
    input  logic [lpm_pkg::NST:1]     en,
    input  logic [lpm_pkg::CRD_W-1:0] p,
    input  logic [lpm_pkg::OFF_W-1:0] off,
    input  logic [lpm_pkg::SZ_W-1:0]  vsz,
    input  logic [lpm_pkg::SZ_W-1:0]  csz,
    output logic [lpm_pkg::CRD_W-1:0] m,
    output logic                      invp
);

    localparam int FB = lpm_pkg::COORD_FRAC_BITS;
    localparam int CW = lpm_pkg::CRD_W;
    localparam int SW = lpm_pkg::SZ_W;

    logic [CW-1:0]               offq, limit;
    logic [SW-1:0]               vend;
    logic [CW:0]                 endq;
    logic [CW-1:0]               d1_reg;
    logic [lpm_pkg::PROD_W-1:0]  n2_reg;
    logic [SW-1:0]               rem_reg [0:lpm_pkg::DIV_STG];
    logic [CW-1:0]               lq_reg  [0:lpm_pkg::DIV_STG];
    logic                        ovf_reg [0:lpm_pkg::DIV_STG];
    logic                        ivp_reg [1:lpm_pkg::ST_MAPPED];
    logic [CW-1:0]               m_reg;

    assign offq  = {off, {FB{1'b0}}};
    assign vend  = SW'({1'b0, off}) + vsz;
    assign endq  = {vend, {FB{1'b0}}};
    assign limit = CW'({SW'(csz - 1'b1), {FB{1'b0}}});

    // Offset into the viewport, and the viewport test
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            d1_reg     <= (p > offq) ? (p - offq) : '0;
            ivp_reg[1] <= (p >= offq) && ({1'b0, p} < endq);
        end
    end

    // Scale by the content size
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            n2_reg     <= d1_reg * csz;
            ivp_reg[2] <= ivp_reg[1];
        end
    end

    // Flag quotients that need more than the coordinate width
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            ovf_reg[0] <= (n2_reg[lpm_pkg::PROD_W-1:CW] >= vsz);
            rem_reg[0] <= n2_reg[lpm_pkg::PROD_W-1:CW];
            lq_reg[0]  <= n2_reg[CW-1:0];
            ivp_reg[3] <= ivp_reg[2];
        end
    end

    // Divide by the viewport size, two quotient bits per stage
    for (genvar i = 0; i < lpm_pkg::DIV_STG; i++) begin : g_div
        logic [SW-1:0] r_c [0:lpm_pkg::STEP_PER];
        logic [CW-1:0] q_c [0:lpm_pkg::STEP_PER];
        logic [SW:0]   sh  [0:lpm_pkg::STEP_PER-1];

        always_comb begin
            r_c[0] = rem_reg[i];
            q_c[0] = lq_reg[i];
            for (int k = 0; k < lpm_pkg::STEP_PER; k++) begin
                sh[k] = {r_c[k], q_c[k][CW-1]};
                if (sh[k] >= {1'b0, vsz}) begin
                    r_c[k+1] = SW'(sh[k] - {1'b0, vsz});
                    q_c[k+1] = {q_c[k][CW-2:0], 1'b1};
                end else begin
                    r_c[k+1] = SW'(sh[k]);
                    q_c[k+1] = {q_c[k][CW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[4+i]) begin
                rem_reg[i+1] <= r_c[lpm_pkg::STEP_PER];
                lq_reg[i+1]  <= q_c[lpm_pkg::STEP_PER];
                ovf_reg[i+1] <= ovf_reg[i];
                ivp_reg[4+i] <= ivp_reg[3+i];
            end
        end
    end

    // Clamp to the last content pixel
    always_ff @(posedge aclk) begin
        if (en[lpm_pkg::ST_MAPPED]) begin
            if (ovf_reg[lpm_pkg::DIV_STG] || lq_reg[lpm_pkg::DIV_STG] > limit)
                m_reg <= limit;
            else
                m_reg <= lq_reg[lpm_pkg::DIV_STG];
            ivp_reg[lpm_pkg::ST_MAPPED] <= ivp_reg[lpm_pkg::ST_MAPPED-1];
        end
    end

    assign m    = m_reg;
    assign invp = ivp_reg[lpm_pkg::ST_MAPPED];

endmodule

### dv/letterbox_pointer_map_shape_test_core_tb.sv
`timescale 1ns / 1ps

module letterbox_pointer_map_shape_test_core_tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int EXP_DEPTH    = 2048;

    typedef struct {
        logic [15:0] cx;
        logic [15:0] cy;
        logic        is_in;
    } mapped_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [15:0]                s_pointer_x = '0;
    logic [15:0]                s_pointer_y = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [15:0]                m_content_x;
    logic [15:0]                m_content_y;
    logic                       m_is_inside;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [lpm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Register shadow
    logic [12:0] sh_render_w = 13'd1;
    logic [12:0] sh_render_h = 13'd1;
    logic [12:0] sh_content_w = 13'd1;
    logic [12:0] sh_content_h = 13'd1;
    logic        sh_aspect = 1'b0;
    logic [1:0]  sh_shape = lpm_pkg::SHAPE_RECT;
    logic [11:0] sh_corner = 12'd0;

    mapped_t     exp_mem [0:EXP_DEPTH-1];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          inside_hits = 0;
    int          config_count = 0;

    letterbox_pointer_map_shape_test_core DUT (.*);

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     exp_wr - exp_rd);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic longint size_clip(longint v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic longint scale_axis(longint p, longint off, longint vsize, longint csize);
        longint offq, lim, m;
        offq = off << lpm_pkg::COORD_FRAC_BITS;
        lim = (csize - 1) << lpm_pkg::COORD_FRAC_BITS;
        if (p <= offq) return 0;
        m = ((p - offq) * csize) / vsize;
        if (m > lim) m = lim;
        if (m > 65535) m = 65535;
        return m;
    endfunction

    // Shape test in doubled fixed point
    function automatic bit shape_hit(longint x, longint y, longint cw, longint ch);
        longint w2, h2, px, py, r, dx, dy;
        w2 = cw << lpm_pkg::COORD_FRAC_BITS;
        h2 = ch << lpm_pkg::COORD_FRAC_BITS;
        px = 2 * x - w2;
        py = 2 * y - h2;
        if (sh_shape == lpm_pkg::SHAPE_CIRCLE) begin
            r = (w2 < h2) ? w2 : h2;
            return px * px + py * py <= r * r;
        end
        if (sh_shape == lpm_pkg::SHAPE_ROUND) begin
            r = (longint'(sh_corner) * 2) << lpm_pkg::COORD_FRAC_BITS;
            if (w2 < r) r = w2;
            if (h2 < r) r = h2;
            dx = (px < 0 ? -px : px) - w2 + r;
            dy = (py < 0 ? -py : py) - h2 + r;
            if (dx <= 0 && dy <= 0) return 1'b1;
            if (dx < 0) dx = 0;
            if (dy < 0) dy = 0;
            return dx * dx + dy * dy <= r * r;
        end
        return 1'b1;
    endfunction

    function automatic mapped_t map_pointer(logic [15:0] pxw, logic [15:0] pyw);
        mapped_t res;
        longint rw, rh, cw, ch, vx, vy, vw, vh, mx, my, px, py;
        bit hit;
        res = '{16'd0, 16'd0, 1'b0};
        if (sh_content_w == 0 || sh_content_h == 0) return res;
        px = pxw;
        py = pyw;
        rw = size_clip(sh_render_w);
        rh = size_clip(sh_render_h);
        cw = size_clip(sh_content_w);
        ch = size_clip(sh_content_h);
        vx = 0; vy = 0; vw = rw; vh = rh;
        // Letterbox: fit the narrower axis, round half up
        if (sh_aspect) begin
            if (rw * ch > cw * rh) begin
                vw = (2 * rh * cw + ch) / (2 * ch);
                if (vw < 1) vw = 1;
                if (vw > rw) vw = rw;
                vx = (rw - vw) / 2;
            end else begin
                vh = (2 * rw * ch + cw) / (2 * cw);
                if (vh < 1) vh = 1;
                if (vh > rh) vh = rh;
                vy = (rh - vh) / 2;
            end
        end
        mx = scale_axis(px, vx, vw, cw);
        my = scale_axis(py, vy, vh, ch);
        hit = px >= (vx << lpm_pkg::COORD_FRAC_BITS) &&
              px < ((vx + vw) << lpm_pkg::COORD_FRAC_BITS) &&
              py >= (vy << lpm_pkg::COORD_FRAC_BITS) &&
              py < ((vy + vh) << lpm_pkg::COORD_FRAC_BITS);
        hit = hit && shape_hit(mx, my, cw, ch);
        res.cx = mx[15:0];
        res.cy = my[15:0];
        res.is_in = hit;
        return res;
    endfunction

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin
        mapped_t exp_map;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word x=%h y=%h in=%b", m_content_x, m_content_y,
                             m_is_inside);
            end else begin
                exp_map = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd = exp_rd + 1;
                words_checked <= words_checked + 1;
                if (m_is_inside) inside_hits <= inside_hits + 1;
                if (m_content_x !== exp_map.cx || m_content_y !== exp_map.cy ||
                    m_is_inside !== exp_map.is_in) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected x=%h y=%h in=%b, got x=%h y=%h in=%b",
                                 exp_map.cx, exp_map.cy, exp_map.is_in,
                                 m_content_x, m_content_y, m_is_inside);
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lpm_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold until every prediction has been matched, then let the pipe settle
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [12:0] rw, input logic [12:0] rh,
                              input logic [12:0] cw, input logic [12:0] ch,
                              input logic aspect, input logic [1:0] shape,
                              input logic [11:0] corner);
        wait_drain();
        apb_write(lpm_pkg::REG_RENDER_W, 32'(rw));
        apb_write(lpm_pkg::REG_RENDER_H, 32'(rh));
        apb_write(lpm_pkg::REG_CONTENT_W, 32'(cw));
        apb_write(lpm_pkg::REG_CONTENT_H, 32'(ch));
        apb_write(lpm_pkg::REG_ASPECT, 32'(aspect));
        apb_write(lpm_pkg::REG_SHAPE, 32'(shape));
        apb_write(lpm_pkg::REG_CORNER, 32'(corner));
        sh_render_w = rw;
        sh_render_h = rh;
        sh_content_w = cw;
        sh_content_h = ch;
        sh_aspect = aspect;
        sh_shape = shape;
        sh_corner = corner;
        config_count++;
    endtask

    // Send one pointer word; valid holds until the handshake
    task automatic send_pointer(input logic [15:0] px, input logic [15:0] py);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pointer_x <= px;
        s_pointer_y <= py;
        do @(posedge aclk); while (!s_ready);
        exp_mem[exp_wr % EXP_DEPTH] = map_pointer(px, py);
        exp_wr = exp_wr + 1;
        words_sent++;
    endtask

    function automatic logic [12:0] pick_size();
        case ($urandom_range(9))
            0: return 13'd1;
            1: return 13'd4096;
            2: return 13'($urandom_range(8191, 4097));
            3: return 13'($urandom_range(4095, 1));
            default: return 13'($urandom_range(900, 2));
        endcase
    endfunction

    function automatic logic [15:0] pick_coord(logic [12:0] rsize);
        longint span;
        span = (size_clip(rsize) << lpm_pkg::COORD_FRAC_BITS) + 32;
        if ($urandom_range(9) < 7) return 16'($urandom_range(span > 65535 ? 65535 : span));
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        logic [12:0] rws[8];
        logic [12:0] rhs[8];
        logic [12:0] cws[8];
        logic [12:0] chs[8];
        logic        asp[8];
        logic [1:0]  shp[8];
        logic [11:0] crn[8];
        // Reset defaults first
        send_pointer(16'h0000, 16'h0000);
        send_pointer(16'hFFFF, 16'hFFFF);
        rws = '{640, 640, 480, 1000, 0, 8191, 300, 200};
        rhs = '{480, 480, 640, 1000, 300, 4096, 200, 0};
        cws = '{320, 320, 320, 4096, 100, 8191, 0, 50};
        chs = '{240, 100, 480, 1024, 100, 4095, 200, 50};
        asp = '{0, 1, 1, 1, 0, 1, 0, 1};
        shp = '{lpm_pkg::SHAPE_RECT, lpm_pkg::SHAPE_ROUND, lpm_pkg::SHAPE_CIRCLE,
                lpm_pkg::SHAPE_ROUND, 2'd3, lpm_pkg::SHAPE_CIRCLE,
                lpm_pkg::SHAPE_RECT, lpm_pkg::SHAPE_ROUND};
        crn = '{0, 4095, 7, 2048, 0, 3000, 0, 10};
        for (int c = 0; c < 8; c++) begin
            set_config(rws[c], rhs[c], cws[c], chs[c], asp[c], shp[c], crn[c]);
            send_pointer(16'(size_clip(rws[c]) * 8), 16'(size_clip(rhs[c]) * 8));
            send_pointer(16'h0010, 16'hFFF0);
        end
    endtask

    task automatic test_random(input int words, input int phases);
        logic [12:0] rw, rh;
        for (int ph = 0; ph < phases; ph++) begin
            rw = pick_size();
            rh = pick_size();
            set_config(rw, rh, ($urandom_range(19) == 0) ? 13'd0 : pick_size(), pick_size(),
                       1'($urandom), 2'($urandom), 12'($urandom));
            for (int i = 0; i < words / phases; i++)
                send_pointer(pick_coord(rw), pick_coord(rh));
        end
    endtask

    task automatic test_full_pressure();
        // Pause the source until the pipe is empty, then stream again
        for (int i = 0; i < 20; i++) send_pointer(16'($urandom), 16'($urandom));
        wait_drain();
        for (int i = 0; i < 20; i++) send_pointer(16'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 33;
        snk_idle_pct = 48;
        test_directed();
        test_random(560, 7);
        src_idle_pct = 48;
        snk_idle_pct = 33;
        test_random(560, 7);
        test_full_pressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(560, 7);
        wait_drain();
        $display("Mapped %0d pointer words over %0d register settings, %0d hits inside shape",
                 words_checked, config_count, inside_hits);
        $display("Covered stretch and letterbox views, all shape codes, zero and oversize sizes");
        if (mismatches == 0 && words_checked == words_sent) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
